### rtl/pnsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsd_pkg
// Shared types, constants and symbol functions of the packed name decoder.
// ----------------------------------------------------------------------------
package pnsd_pkg;

   // Name store size and the position counter that must reach it
   localparam int MAX_NAME_LEN = 256;
   localparam int POS_W        = $clog2(MAX_NAME_LEN + 1);

   // Result queue
   localparam int QUEUE_DEPTH  = 4;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Symbol and character constants
   localparam logic [5:0] SYM_HDR_MIN  = 6'h30;
   localparam logic [7:0] CHAR_INVALID = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_TERM    = 8'h00;

   // Byte phases of the three-byte symbol group
   localparam logic [1:0] BP_FIRST  = 2'd0;
   localparam logic [1:0] BP_SECOND = 2'd1;
   localparam logic [1:0] BP_THIRD  = 2'd2;

   typedef enum logic [1:0] {
      HP_FIRST,
      HP_SECOND,
      HP_BODY,
      HP_DONE
   } hp_type;

   typedef enum logic [1:0] {
      ERR_OK,
      ERR_DELTA,
      ERR_CHAR,
      ERR_LONG
   } err_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] char_pos;
      logic [6:0] keep_count;
      logic       name_end;
      err_type    error_code;
      logic       last_of_item;
   } rsp_type;

   typedef struct packed {
      hp_type           phase;
      logic [2:0]       hdr_low;
      logic [POS_W-1:0] pos;
      logic [6:0]       keep;
   } dec_state_type;

   typedef struct packed {
      dec_state_type st;
      logic          emit;
      rsp_type       res;
   } step_type;

   typedef struct packed {
      logic    emit_a;
      logic    emit_b;
      rsp_type res_a;
      rsp_type res_b;
   } dec_out_type;

   localparam dec_state_type ST_RESET = '{HP_FIRST, 3'd0, {POS_W{1'b0}}, 7'd0};

   // Fixed 64-entry character table
   function automatic logic [7:0] char_map(input logic [5:0] sym);
      logic [7:0] c;
      logic [7:0] s;
      s = {2'b00, sym};
      c = CHAR_INVALID;
      if (sym < 6'd10) begin
         case (sym[3:0])
            4'd0:    c = CHAR_TERM;
            4'd1:    c = 8'h20;
            4'd2:    c = 8'h23;
            4'd3:    c = 8'h24;
            4'd4:    c = 8'h28;
            4'd5:    c = 8'h29;
            4'd6:    c = 8'h2D;
            4'd7:    c = 8'h2E;
            4'd8:    c = 8'h2F;
            4'd9:    c = 8'h3F;
            default: c = CHAR_INVALID;
         endcase
      end else if (sym < 6'd20) begin
         c = 8'h30 + (s - 8'd10);
      end else if (sym == 6'd20) begin
         c = 8'h5F;
      end else if (sym < 6'd47) begin
         c = 8'h61 + (s - 8'd21);
      end else if (sym == 6'd47) begin
         c = 8'h7E;
      end
      return c;
   endfunction

   // Emit a character, terminator or error result at the current position
   function automatic step_type emit_body(input dec_state_type st, input logic [5:0] sym);
      step_type   o;
      logic [7:0] c;
      o      = '0;
      o.st   = st;
      o.emit = 1'b1;
      o.res.char_pos   = st.pos[7:0];
      o.res.keep_count = st.keep;
      o.res.error_code = ERR_OK;
      c = char_map(sym);
      if (st.pos >= POS_W'(MAX_NAME_LEN)) begin
         o.res.error_code = ERR_LONG;
         o.st.phase       = HP_DONE;
      end else if (c == CHAR_INVALID) begin
         o.res.char_code  = c;
         o.res.error_code = ERR_CHAR;
         o.st.phase       = HP_DONE;
      end else if (c == CHAR_TERM) begin
         o.res.name_end = 1'b1;
         o.st.phase     = HP_DONE;
      end else begin
         o.res.char_code = c;
         o.st.pos        = st.pos + 1'b1;
      end
      return o;
   endfunction

   // Take one symbol through the header and body logic
   function automatic step_type take_symbol(input dec_state_type st, input logic [5:0] sym);
      step_type      o;
      dec_state_type s;
      o    = '0;
      o.st = st;
      s    = st;
      case (st.phase)
         HP_FIRST: begin
            if (sym >= SYM_HDR_MIN) begin
               if (sym[5:3] != 3'b111) begin
                  o.emit           = 1'b1;
                  o.res.error_code = ERR_DELTA;
                  o.st.phase       = HP_DONE;
               end else begin
                  o.st.hdr_low = sym[2:0];
                  o.st.phase   = HP_SECOND;
               end
            end else begin
               s.keep  = 7'd0;
               s.pos   = '0;
               s.phase = HP_BODY;
               o       = emit_body(s, sym);
            end
         end
         HP_SECOND: begin
            if (sym[5:4] != 2'b10) begin
               o.emit           = 1'b1;
               o.res.error_code = ERR_DELTA;
               o.st.phase       = HP_DONE;
            end else begin
               o.st.keep  = {sym[3:0], st.hdr_low};
               o.st.pos   = POS_W'({sym[3:0], st.hdr_low});
               o.st.phase = HP_BODY;
            end
         end
         HP_BODY: begin
            o = emit_body(st, sym);
         end
         default: begin
            o.emit = 1'b0;
         end
      endcase
      return o;
   endfunction

endpackage

### rtl/pnsd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsd_req_if
// Byte channel into the packed name decoder.
// ----------------------------------------------------------------------------
interface pnsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       name_start;

   modport source (output valid, output name_byte, output name_start, input ready);
   modport sink   (input valid, input name_byte, input name_start, output ready);
endinterface

### rtl/pnsd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsd_rsp_if
// Character result channel out of the packed name decoder.
// ----------------------------------------------------------------------------
interface pnsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic [7:0] char_pos;
   logic [6:0] keep_count;
   logic       name_end;
   logic [1:0] error_code;
   logic       last_of_item;

   modport source (output valid, output char_code, output char_pos, output keep_count,
                   output name_end, output error_code, output last_of_item, input ready);
   modport sink   (input valid, input char_code, input char_pos, input keep_count,
                   input name_end, input error_code, input last_of_item, output ready);
endinterface

### rtl/pnsd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsd_decode
// Unpacks up to two 6-bit symbols from each byte, runs the delta header and
// character logic on them in order and holds the per-name state.
// ----------------------------------------------------------------------------
module pnsd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           name_byte,
   input  logic                 name_start,
   output pnsd_pkg::dec_out_type dec_out
);

   logic [1:0]              byte_phase_ff, byte_phase_in;
   logic [3:0]              carry_ff, carry_in;
   pnsd_pkg::dec_state_type st_ff, st_in;

   logic [1:0]              bp0;
   logic [3:0]              carry0;
   pnsd_pkg::dec_state_type st0;
   logic [5:0]              sym_a, sym_b;
   logic                    two_sym;
   pnsd_pkg::step_type      step_a, step_b;

   // Unpack symbols and step the header and body logic
   always_comb begin
      st0    = name_start ? pnsd_pkg::ST_RESET : st_ff;
      bp0    = name_start ? pnsd_pkg::BP_FIRST : byte_phase_ff;
      carry0 = name_start ? 4'd0 : carry_ff;
      sym_b  = name_byte[7:2];
      case (bp0)
         pnsd_pkg::BP_FIRST: begin
            sym_a         = name_byte[5:0];
            two_sym       = 1'b0;
            carry_in      = {2'b00, name_byte[7:6]};
            byte_phase_in = pnsd_pkg::BP_SECOND;
         end
         pnsd_pkg::BP_SECOND: begin
            sym_a         = {name_byte[3:0], carry0[1:0]};
            two_sym       = 1'b0;
            carry_in      = name_byte[7:4];
            byte_phase_in = pnsd_pkg::BP_THIRD;
         end
         default: begin
            sym_a         = {name_byte[1:0], carry0};
            two_sym       = 1'b1;
            carry_in      = 4'd0;
            byte_phase_in = pnsd_pkg::BP_FIRST;
         end
      endcase

      step_a = pnsd_pkg::take_symbol(st0, sym_a);
      step_b = pnsd_pkg::take_symbol(step_a.st, sym_b);
      st_in  = two_sym ? step_b.st : step_a.st;

      dec_out.emit_a = accept & step_a.emit;
      dec_out.emit_b = accept & two_sym & step_b.emit;
      dec_out.res_a  = step_a.res;
      dec_out.res_a.last_of_item = ~(two_sym & step_b.emit);
      dec_out.res_b  = step_b.res;
      dec_out.res_b.last_of_item = 1'b1;
   end

   // Advance the name state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= pnsd_pkg::BP_FIRST;
         carry_ff      <= 4'd0;
         st_ff         <= pnsd_pkg::ST_RESET;
      end else if (accept) begin
         byte_phase_ff <= byte_phase_in;
         carry_ff      <= carry_in;
         st_ff         <= st_in;
      end
   end

endmodule

### rtl/packed_name_symbol_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_name_symbol_decoder_top
// Decodes a packed name byte stream into characters with their positions.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   name_byte, name_start
//   rsp_chan  out  valid/ready   char_code, char_pos, keep_count, name_end,
//                                error_code, last_of_item
//
// One byte is taken per cycle; its zero, one or two results are written to a
// four-entry result queue in the same edge and leave one per cycle.
// A byte is taken while the queue holds two entries or fewer, so the output
// port, at one result a cycle, sets the sustained rate.
// Reset is synchronous; it empties the queue and returns to the start of a name.
// Stalls on rsp_chan fill the queue and then hold off req_chan.
// ----------------------------------------------------------------------------
module packed_name_symbol_decoder_top (
   input  logic         clock,
   input  logic         reset,
   pnsd_req_if.sink     req_chan,
   pnsd_rsp_if.source   rsp_chan
);

   logic                      accept;
   logic                      pop;
   pnsd_pkg::dec_out_type     dec_out;

   pnsd_pkg::rsp_type         queue_ff [pnsd_pkg::QUEUE_DEPTH];
   logic [pnsd_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pnsd_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pnsd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [pnsd_pkg::PTR_W-1:0] wr_b_ptr;
   pnsd_pkg::rsp_type         head;

   // Handshakes
   assign req_chan.ready = count_ff <= pnsd_pkg::CNT_W'(pnsd_pkg::QUEUE_DEPTH - 2);
   assign accept         = req_chan.valid & req_chan.ready;
   assign rsp_chan.valid = count_ff != '0;
   assign pop            = rsp_chan.valid & rsp_chan.ready;

   pnsd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .name_byte  (req_chan.name_byte),
      .name_start (req_chan.name_start),
      .dec_out    (dec_out)
   );

   // Queue pointers and fill level
   always_comb begin
      wr_b_ptr  = wr_ptr_ff + pnsd_pkg::PTR_W'(dec_out.emit_a);
      wr_ptr_in = wr_b_ptr + pnsd_pkg::PTR_W'(dec_out.emit_b);
      rd_ptr_in = rd_ptr_ff + pnsd_pkg::PTR_W'(pop);
      count_in  = count_ff + pnsd_pkg::CNT_W'(dec_out.emit_a)
                           + pnsd_pkg::CNT_W'(dec_out.emit_b)
                           - pnsd_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold results in the queue
   always_ff @(posedge clock) begin
      if (dec_out.emit_a) begin
         queue_ff[wr_ptr_ff] <= dec_out.res_a;
      end
      if (dec_out.emit_b) begin
         queue_ff[wr_b_ptr] <= dec_out.res_b;
      end
   end

   // Drive the result channel from the queue head
   assign head                  = queue_ff[rd_ptr_ff];
   assign rsp_chan.char_code    = head.char_code;
   assign rsp_chan.char_pos     = head.char_pos;
   assign rsp_chan.keep_count   = head.keep_count;
   assign rsp_chan.name_end     = head.name_end;
   assign rsp_chan.error_code   = head.error_code;
   assign rsp_chan.last_of_item = head.last_of_item;

   // Queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pnsd_pkg::CNT_W'(pnsd_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   // A terminator always comes without an error
   a_end_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.name_end |-> rsp_chan.error_code == pnsd_pkg::ERR_OK)
      else $error("terminator carries an error");

   // A bad delta header carries no position or kept length
   a_delta_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error_code == pnsd_pkg::ERR_DELTA |->
         rsp_chan.char_pos == 8'd0 && rsp_chan.keep_count == 7'd0)
      else $error("delta error result not cleared");

   // A second result of one byte is only written beside a taken byte
   a_push_accept: assert property (@(posedge clock) disable iff (reset)
      dec_out.emit_b |-> accept && count_ff <= pnsd_pkg::CNT_W'(pnsd_pkg::QUEUE_DEPTH - 2))
      else $error("result written without room");

endmodule
